// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define RQY_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked at every rising edge, reset included
`define RQY_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rqy_pkg.sv =====
// types and fixed conversion constants for the rgb quad to yuv420 unit
`default_nettype none

package rqy_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned COEF_W = 9;
  localparam int unsigned PROD_W = 18;
  localparam int unsigned SUM_W  = 19;
  localparam int unsigned NUM_PIX = 4;

  // luma row
  localparam logic signed [COEF_W-1:0] Y_R  =  9'sd76;
  localparam logic signed [COEF_W-1:0] Y_G  =  9'sd150;
  localparam logic signed [COEF_W-1:0] Y_B  =  9'sd29;
  // blue-difference row
  localparam logic signed [COEF_W-1:0] CB_R = -9'sd43;
  localparam logic signed [COEF_W-1:0] CB_G = -9'sd84;
  localparam logic signed [COEF_W-1:0] CB_B =  9'sd127;
  // red-difference row
  localparam logic signed [COEF_W-1:0] CR_R =  9'sd127;
  localparam logic signed [COEF_W-1:0] CR_G = -9'sd106;
  localparam logic signed [COEF_W-1:0] CR_B = -9'sd21;

  // 128 scaled by 256, added before the shift so it works as a floor
  localparam logic signed [SUM_W-1:0] CHROMA_BIAS = 19'sd32768;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic [CH_W-1:0] y;
    logic [CH_W-1:0] cb;
    logic [CH_W-1:0] cr;
  } yuv_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rqy_pixel.sv =====
// one pixel's luma and biased chroma: products stage, then sum and shift stage
`default_nettype none

module rqy_pixel (
  input  wire logic          clk,
  input  wire rqy_pkg::rgb_t px,
  output rqy_pkg::yuv_t      res
);

  localparam int unsigned PW = rqy_pkg::PROD_W;
  localparam int unsigned SW = rqy_pkg::SUM_W;

  logic signed [rqy_pkg::COEF_W-1:0] r_s, g_s, b_s;

  logic signed [PW-1:0] yr, yg, yb;
  logic signed [PW-1:0] ur, ug, ub;
  logic signed [PW-1:0] vr, vg, vb;

  logic signed [SW-1:0] y_sum, u_sum, v_sum;
  logic signed [SW-1:0] u_biased, v_biased;

  assign r_s = signed'({1'b0, px.r});
  assign g_s = signed'({1'b0, px.g});
  assign b_s = signed'({1'b0, px.b});

  // stage 1: nine constant products, operands widened so nothing overflows
  always_ff @(posedge clk) begin
    yr <= PW'(r_s) * PW'(rqy_pkg::Y_R);
    yg <= PW'(g_s) * PW'(rqy_pkg::Y_G);
    yb <= PW'(b_s) * PW'(rqy_pkg::Y_B);
    ur <= PW'(r_s) * PW'(rqy_pkg::CB_R);
    ug <= PW'(g_s) * PW'(rqy_pkg::CB_G);
    ub <= PW'(b_s) * PW'(rqy_pkg::CB_B);
    vr <= PW'(r_s) * PW'(rqy_pkg::CR_R);
    vg <= PW'(g_s) * PW'(rqy_pkg::CR_G);
    vb <= PW'(b_s) * PW'(rqy_pkg::CR_B);
  end

  always_comb begin
    y_sum    = SW'(yr) + SW'(yg) + SW'(yb);
    u_sum    = SW'(ur) + SW'(ug) + SW'(ub);
    v_sum    = SW'(vr) + SW'(vg) + SW'(vb);
    u_biased = u_sum + rqy_pkg::CHROMA_BIAS;
    v_biased = v_sum + rqy_pkg::CHROMA_BIAS;
  end

  // stage 2: all sums land in 0..65535, so bits 15:8 are the shifted value
  always_ff @(posedge clk) begin
    res.y  <= y_sum[15:8];
    res.cb <= u_biased[15:8];
    res.cr <= v_biased[15:8];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_quad_to_yuv420_unit.sv =====
// top level: 2x2 rgb quad to four luma samples and one averaged chroma pair
//
// usage:
//   a request is taken at a rising edge with start high and busy low. busy
//   is held low: the unit is a three-stage pipeline and takes a new quad in
//   every cycle, one quad per cycle sustained.
//   stage 1 forms the nine constant products of each pixel, stage 2 sums
//   them and shifts to 8-bit luma and biased chroma, stage 3 averages the
//   four chroma values and registers all six results.
//   a result shows with done high once stage 3 has registered it, and the
//   results stay on the ports for that one cycle.
//   the receiver cannot hold results off, so nothing ever stalls.
//   reset (rst, synchronous, active high) clears the valid bits of all
//   stages; requests in flight are dropped and done stays low.
`default_nettype none

module rgb_quad_to_yuv420_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] red_top_left,
  input  wire logic [7:0] green_top_left,
  input  wire logic [7:0] blue_top_left,
  input  wire logic [7:0] red_top_right,
  input  wire logic [7:0] green_top_right,
  input  wire logic [7:0] blue_top_right,
  input  wire logic [7:0] red_bottom_left,
  input  wire logic [7:0] green_bottom_left,
  input  wire logic [7:0] blue_bottom_left,
  input  wire logic [7:0] red_bottom_right,
  input  wire logic [7:0] green_bottom_right,
  input  wire logic [7:0] blue_bottom_right,
  output logic            done,
  output logic [7:0]      luma_top_left,
  output logic [7:0]      luma_top_right,
  output logic [7:0]      luma_bottom_left,
  output logic [7:0]      luma_bottom_right,
  output logic [7:0]      chroma_blue_avg,
  output logic [7:0]      chroma_red_avg
);

  localparam int unsigned NP    = rqy_pkg::NUM_PIX;
  localparam int unsigned CW    = rqy_pkg::CH_W;
  localparam int unsigned ACC_W = CW + $clog2(NP);

  rqy_pkg::rgb_t px  [NP];
  rqy_pkg::yuv_t pix [NP];

  logic valid1, valid2, valid3;

  logic [ACC_W-1:0] cb_acc, cr_acc;

  assign busy = 1'b0;

  assign px[0] = '{r: red_top_left,     g: green_top_left,     b: blue_top_left};
  assign px[1] = '{r: red_top_right,    g: green_top_right,    b: blue_top_right};
  assign px[2] = '{r: red_bottom_left,  g: green_bottom_left,  b: blue_bottom_left};
  assign px[3] = '{r: red_bottom_right, g: green_bottom_right, b: blue_bottom_right};

  for (genvar i = 0; i < NP; i++) begin : g_pix
    rqy_pixel u_pix (
      .clk (clk),
      .px  (px[i]),
      .res (pix[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else begin
      valid1 <= start && !busy;
      valid2 <= valid1;
      valid3 <= valid2;
    end
  end

  always_comb begin
    cb_acc = '0;
    cr_acc = '0;
    for (int i = 0; i < NP; i++) begin
      cb_acc = cb_acc + ACC_W'(pix[i].cb);
      cr_acc = cr_acc + ACC_W'(pix[i].cr);
    end
  end

  // stage 3: truncating average of the four chroma values, registered with the four luma values
  always_ff @(posedge clk) begin
    luma_top_left     <= pix[0].y;
    luma_top_right    <= pix[1].y;
    luma_bottom_left  <= pix[2].y;
    luma_bottom_right <= pix[3].y;
    chroma_blue_avg   <= cb_acc[ACC_W-1 -: CW];
    chroma_red_avg    <= cr_acc[ACC_W-1 -: CW];
  end

  assign done = valid3;

endmodule

`default_nettype wire

// ===== hw/rtl/rqy_checker.sv =====
// port-level checks for the rgb quad to yuv420 unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module rqy_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [7:0] luma_top_left,
  input wire logic [7:0] luma_top_right,
  input wire logic [7:0] luma_bottom_left,
  input wire logic [7:0] luma_bottom_right,
  input wire logic [7:0] chroma_blue_avg,
  input wire logic [7:0] chroma_red_avg
);

  logic results_in_range;

  // luma tops out at 254, averaged chroma stays within 1..254
  assign results_in_range = luma_top_left != 8'hff && luma_top_right != 8'hff &&
                            luma_bottom_left != 8'hff && luma_bottom_right != 8'hff &&
                            chroma_blue_avg != 8'h00 && chroma_blue_avg != 8'hff &&
                            chroma_red_avg != 8'h00 && chroma_red_avg != 8'hff;

  // every result goes back to a request taken outside reset
  `RQY_ASSERT(a_done_has_request, clk, rst, done |-> $past(start && !busy && !rst, 3))
  // every request comes out with done high
  `RQY_ASSERT(a_request_gives_done, clk, rst, (start && !busy) |-> ##3 done)
  // the pipeline never refuses a request
  `RQY_ASSERT_ALWAYS(a_never_busy, clk, !busy)
  // results stay inside the reachable range of the matrix
  `RQY_ASSERT(a_result_range, clk, rst, done |-> results_in_range)

endmodule

bind rgb_quad_to_yuv420_unit rqy_checker u_rqy_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .done              (done),
  .luma_top_left     (luma_top_left),
  .luma_top_right    (luma_top_right),
  .luma_bottom_left  (luma_bottom_left),
  .luma_bottom_right (luma_bottom_right),
  .chroma_blue_avg   (chroma_blue_avg),
  .chroma_red_avg    (chroma_red_avg)
);

`default_nettype wire
